[rtl/cta_pkg.sv]
// Shared types, constants and the genetic code lookup for the codon translator.
package cta_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned OffsetWidth = 8;
   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned CsrDataWidth = 8;

   localparam logic [CsrIdxWidth-1:0] CSR_FRAME_OFFSET = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RETAIN_GAPS  = 1'd1;

   localparam logic [1:0] BASE_T = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_A = 2'd2;
   localparam logic [1:0] BASE_G = 2'd3;

   localparam logic [CharWidth-1:0] CHAR_T     = 8'h54;
   localparam logic [CharWidth-1:0] CHAR_C     = 8'h43;
   localparam logic [CharWidth-1:0] CHAR_A     = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_G     = 8'h47;
   localparam logic [CharWidth-1:0] CHAR_X     = 8'h58;
   localparam logic [CharWidth-1:0] CHAR_GAP   = 8'h2D;
   localparam logic [CharWidth-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [CharWidth-1:0] CASE_SHIFT = 8'h20;

   localparam logic [64*CharWidth-1:0] CODE_TABLE =
      {"FFLLSSSSYY**CC*W", "LLLLPPPPHHQQRRRR",
       "IIIMTTTTNNKKSSRR", "VVVVAAAADDEEGGGG"};

   typedef struct packed {
      logic [CharWidth-1:0] residue;
      logic                 residue_valid;
      logic                 seq_end;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
      logic       gap;
   } base_info_type;

   // First character of the table sits in the top byte.
   function automatic logic [CharWidth-1:0] code_lookup(input logic [5:0] idx);
      code_lookup = CODE_TABLE[{~idx, 3'b000} +: CharWidth];
   endfunction

   function automatic base_info_type decode_base(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] upper;
      base_info_type        info;
      upper = ch;
      if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
         upper = ch - CASE_SHIFT;
      end
      info.gap = (ch == CHAR_GAP);
      info.valid = 1'b1;
      info.code = BASE_T;
      if (upper == CHAR_T) begin
         info.code = BASE_T;
      end else if (upper == CHAR_C) begin
         info.code = BASE_C;
      end else if (upper == CHAR_A) begin
         info.code = BASE_A;
      end else if (upper == CHAR_G) begin
         info.code = BASE_G;
      end else begin
         info.valid = 1'b0;
      end
      decode_base = info;
   endfunction

endpackage

[rtl/cta_codon_unit.sv]
// Frame skip, codon assembly and residue lookup for one accepted character.
module cta_codon_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [cta_pkg::CharWidth-1:0]      base_char,
   input  logic                               seq_last,
   input  logic [cta_pkg::OffsetWidth-1:0]    frame_offset,
   input  logic                               retain_gaps,
   output logic                               has_result,
   output cta_pkg::result_type                result
);

   logic [cta_pkg::OffsetWidth-1:0] skipped_ff, skipped_in;
   logic [1:0]                      position_ff, position_in;
   logic [3:0]                      held_bases_ff, held_bases_in;
   logic                            held_invalid_ff, held_invalid_in;
   logic                            held_gap_ff, held_gap_in;

   cta_pkg::base_info_type info;
   logic                   skipping;
   logic                   codon_done;
   logic [1:0]             bits;

   always_comb begin
      info        = cta_pkg::decode_base(base_char);
      bits        = info.valid ? info.code : cta_pkg::BASE_T;
      skipping    = (skipped_ff < frame_offset);
      codon_done  = !skipping && (position_ff == 2'd2);

      skipped_in      = skipped_ff;
      position_in     = position_ff;
      held_bases_in   = held_bases_ff;
      held_invalid_in = held_invalid_ff;
      held_gap_in     = held_gap_ff;

      result.residue       = '0;
      result.residue_valid = codon_done;
      result.seq_end       = seq_last;

      if (skipping) begin
         skipped_in = skipped_ff + 1'b1;
      end else if (position_ff == 2'd0) begin
         held_bases_in   = {2'b00, bits};
         held_invalid_in = !info.valid;
         held_gap_in     = info.gap;
         position_in     = 2'd1;
      end else if (position_ff == 2'd1) begin
         held_bases_in   = {held_bases_ff[1:0], bits};
         held_invalid_in = held_invalid_ff | !info.valid;
         held_gap_in     = held_gap_ff | info.gap;
         position_in     = 2'd2;
      end else begin
         if (retain_gaps && (held_gap_ff || info.gap)) begin
            result.residue = cta_pkg::CHAR_GAP;
         end else if (held_invalid_ff || !info.valid) begin
            result.residue = cta_pkg::CHAR_X;
         end else begin
            result.residue = cta_pkg::code_lookup({held_bases_ff, bits});
         end
         held_bases_in   = '0;
         held_invalid_in = 1'b0;
         held_gap_in     = 1'b0;
         position_in     = 2'd0;
      end

      if (seq_last) begin
         skipped_in      = '0;
         position_in     = 2'd0;
         held_bases_in   = '0;
         held_invalid_in = 1'b0;
         held_gap_in     = 1'b0;
      end

      has_result = codon_done || seq_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skipped_ff      <= '0;
         position_ff     <= 2'd0;
         held_bases_ff   <= '0;
         held_invalid_ff <= 1'b0;
         held_gap_ff     <= 1'b0;
      end else if (accept) begin
         skipped_ff      <= skipped_in;
         position_ff     <= position_in;
         held_bases_ff   <= held_bases_in;
         held_invalid_ff <= held_invalid_in;
         held_gap_ff     <= held_gap_in;
      end
   end

endmodule

[rtl/cta_out_buffer.sv]
// Result register with a skid entry so input acceptance survives one output stall.
module cta_out_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cta_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output cta_pkg::result_type out_data
);

   logic                out_valid_ff, skid_valid_ff;
   cta_pkg::result_type out_data_ff, skid_data_ff;
   logic                pop;

   assign pop       = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= push_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

[rtl/codon_to_amino_acid_translator.sv]
// Top level of the codon translator: registers, codon unit and result buffer.
// Each result is registered in the output register or skid entry before it reaches rsp_*.
// Throughput: one character per cycle while req_stall is low; req_stall rises only while
// a result is held in the skid entry behind a stalled output register.
// Reset (synchronous, active high) clears the frame count, codon state, both registers
// and the result buffer.
module codon_to_amino_acid_translator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cta_pkg::CharWidth-1:0]       req_base_char,
   input  logic                                req_seq_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cta_pkg::CharWidth-1:0]       rsp_residue,
   output logic                                rsp_residue_valid,
   output logic                                rsp_seq_end,
   input  logic                                csr_write_enable,
   input  logic [cta_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [cta_pkg::CsrDataWidth-1:0]    csr_write_data
);

   logic [cta_pkg::OffsetWidth-1:0] frame_offset_ff;
   logic                            retain_gaps_ff;
   logic                            accept;
   logic                            has_result;
   logic                            buffer_full;
   cta_pkg::result_type             result;
   cta_pkg::result_type             rsp_data;

   assign req_stall = buffer_full;
   assign accept    = req_valid && !buffer_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_offset_ff <= '0;
         retain_gaps_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cta_pkg::CSR_FRAME_OFFSET: frame_offset_ff <= csr_write_data[cta_pkg::OffsetWidth-1:0];
            cta_pkg::CSR_RETAIN_GAPS:  retain_gaps_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   cta_codon_unit u_codon (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .base_char    (req_base_char),
      .seq_last     (req_seq_last),
      .frame_offset (frame_offset_ff),
      .retain_gaps  (retain_gaps_ff),
      .has_result   (has_result),
      .result       (result)
   );

   cta_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && has_result),
      .push_data (result),
      .full      (buffer_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_residue       = rsp_data.residue;
   assign rsp_residue_valid = rsp_data.residue_valid;
   assign rsp_seq_end       = rsp_data.seq_end;

endmodule

[rtl/cta_checker.sv]
// Port-level checks for the codon translator, bound to the top level.
module cta_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [cta_pkg::CharWidth-1:0] rsp_residue,
   input logic                          rsp_residue_valid,
   input logic                          rsp_seq_end
);

   // Hold a stalled transaction unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residue)
         && $stable(rsp_residue_valid) && $stable(rsp_seq_end))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // An end-only result carries no residue.
   a_end_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_residue_valid |-> rsp_seq_end && (rsp_residue == '0))
      else $error("result without codon is not an end-only result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a stalled output");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind codon_to_amino_acid_translator cta_checker u_cta_checker (.*);

[tb/tb_codon_to_amino_acid_translator.sv]
// Self-checking testbench for the codon translator: scoreboard, stimulus and handshake drivers.
`timescale 1ns / 1ps

class residue_tracker;
   cta_pkg::result_type  expected_residues[$];
   string                genetic_code;
   logic [7:0]           frame_offset_reg;
   logic                 retain_gaps_reg;
   logic [7:0]           skip_count;
   logic [1:0]           codon_pos;
   logic [3:0]           held_codes;
   logic                 held_bad;
   logic                 held_dash;
   int                   chars_seen;
   int                   residues_seen;
   int                   codons_seen;
   int                   end_marks;
   int                   errors;

   function new();
      genetic_code = "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      frame_offset_reg = '0;
      retain_gaps_reg  = 1'b0;
      clear_sequence();
      chars_seen    = 0;
      residues_seen = 0;
      codons_seen   = 0;
      end_marks     = 0;
      errors        = 0;
   endfunction

   function void clear_sequence();
      skip_count = '0;
      codon_pos  = '0;
      held_codes = '0;
      held_bad   = 1'b0;
      held_dash  = 1'b0;
   endfunction

   function void set_reg(logic [cta_pkg::CsrIdxWidth-1:0] idx,
                         logic [cta_pkg::CsrDataWidth-1:0] val);
      if (idx == cta_pkg::CSR_FRAME_OFFSET) begin
         frame_offset_reg = val;
      end else if (idx == cta_pkg::CSR_RETAIN_GAPS) begin
         retain_gaps_reg = val[0];
      end
   endfunction

   function int pending();
      return expected_residues.size();
   endfunction

   // Advance the translation state by one character and queue any residue or end mark it yields.
   function void note_input(logic [cta_pkg::CharWidth-1:0] ch, logic last);
      cta_pkg::result_type           r;
      logic [cta_pkg::CharWidth-1:0] up;
      logic [1:0]                    bits;
      logic                          bad;
      logic                          dash;
      logic                          got;
      got = 1'b0;
      r   = '0;
      chars_seen++;
      if (skip_count < frame_offset_reg) begin
         if (skip_count != 8'hFF) begin
            skip_count++;
         end
      end else begin
         up = ch;
         if (ch >= cta_pkg::CHAR_LOW_A && ch <= cta_pkg::CHAR_LOW_Z) begin
            up = ch - cta_pkg::CASE_SHIFT;
         end
         bad  = 1'b0;
         bits = cta_pkg::BASE_T;
         if (up == cta_pkg::CHAR_T) begin
            bits = cta_pkg::BASE_T;
         end else if (up == cta_pkg::CHAR_C) begin
            bits = cta_pkg::BASE_C;
         end else if (up == cta_pkg::CHAR_A) begin
            bits = cta_pkg::BASE_A;
         end else if (up == cta_pkg::CHAR_G) begin
            bits = cta_pkg::BASE_G;
         end else begin
            bad = 1'b1;
         end
         dash = (ch == cta_pkg::CHAR_GAP);
         if (codon_pos == 2'd0) begin
            held_codes = {2'b00, bits};
            held_bad   = bad;
            held_dash  = dash;
            codon_pos  = 2'd1;
         end else if (codon_pos == 2'd1) begin
            held_codes = {held_codes[1:0], bits};
            held_bad   = held_bad | bad;
            held_dash  = held_dash | dash;
            codon_pos  = 2'd2;
         end else begin
            if (retain_gaps_reg && (held_dash || dash)) begin
               r.residue = cta_pkg::CHAR_GAP;
            end else if (held_bad || bad) begin
               r.residue = cta_pkg::CHAR_X;
            end else begin
               r.residue = genetic_code[int'({held_codes, bits})];
            end
            got        = 1'b1;
            codon_pos  = '0;
            held_codes = '0;
            held_bad   = 1'b0;
            held_dash  = 1'b0;
         end
      end
      if (!got && !last) begin
         return;
      end
      r.residue_valid = got;
      r.seq_end       = last;
      expected_residues = {expected_residues, r};
      if (last) begin
         clear_sequence();
      end
   endfunction

   function void check_result(logic [cta_pkg::CharWidth-1:0] residue, logic residue_valid,
                              logic seq_end);
      cta_pkg::result_type exp_r;
      residues_seen++;
      if (residue_valid) begin
         codons_seen++;
      end
      if (seq_end) begin
         end_marks++;
      end
      if (expected_residues.size() == 0) begin
         $display("%0t unexpected result: residue %h valid %b end %b",
                  $time, residue, residue_valid, seq_end);
         errors++;
         return;
      end
      exp_r = expected_residues.pop_front();
      if (residue !== exp_r.residue) begin
         $display("%0t residue mismatch: expected %h actual %h", $time, exp_r.residue, residue);
         errors++;
      end
      if (residue_valid !== exp_r.residue_valid) begin
         $display("%0t residue_valid mismatch: expected %b actual %b",
                  $time, exp_r.residue_valid, residue_valid);
         errors++;
      end
      if (seq_end !== exp_r.seq_end) begin
         $display("%0t seq_end mismatch: expected %b actual %b", $time, exp_r.seq_end, seq_end);
         errors++;
      end
   endfunction
endclass

module tb_codon_to_amino_acid_translator;

   localparam int ItemTarget    = 1900;
   localparam int HoldoffCycles = 150;
   localparam int TailCycles    = 8;

   logic                             clock;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic [cta_pkg::CharWidth-1:0]    req_base_char    = '0;
   logic                             req_seq_last     = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic [cta_pkg::CharWidth-1:0]    rsp_residue;
   logic                             rsp_residue_valid;
   logic                             rsp_seq_end;
   logic                             csr_write_enable = 1'b0;
   logic [cta_pkg::CsrIdxWidth-1:0]  csr_index        = '0;
   logic [cta_pkg::CsrDataWidth-1:0] csr_write_data   = '0;

   bit              quiet           = 1'b0;
   bit              holdoff_pending = 1'b0;
   int              chars_sent      = 0;
   int              phases_run      = 0;
   residue_tracker  tracker;

   codon_to_amino_acid_translator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_char    (req_base_char),
      .req_seq_last     (req_seq_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_residue      (rsp_residue),
      .rsp_residue_valid(rsp_residue_valid),
      .rsp_seq_end      (rsp_seq_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("codon_to_amino_acid_translator regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_input(req_base_char, req_seq_last);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_result(rsp_residue, rsp_residue_valid, rsp_seq_end);
         end
      end
   end

   // Hold off for a long stretch on request, otherwise stall at random unless quiet.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldoffCycles) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   task automatic send_char(input logic [cta_pkg::CharWidth-1:0] ch, input logic last);
      if (!quiet && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 30);
      end
      req_valid     <= 1'b1;
      req_base_char <= ch;
      req_seq_last  <= last;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit end_mark);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], end_mark && (i == s.len() - 1));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cta_pkg::CsrIdxWidth-1:0] idx,
                            input logic [cta_pkg::CsrDataWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_reg(idx, val);
   endtask

   initial begin : stimulus
      int                            ph;
      int                            nseq;
      int                            len;
      int                            off;
      int                            pick;
      bit                            noisy;
      logic [cta_pkg::CharWidth-1:0] ch;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_reg(cta_pkg::CSR_FRAME_OFFSET, 8'd0);
      write_reg(cta_pkg::CSR_RETAIN_GAPS, 8'd0);
      send_text("aTg", 1'b1);
      send_text("TAAG", 1'b1);
      send_text("T-A", 1'b1);
      send_text("N", 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h60, 1'b0);
      send_char(8'h7B, 1'b1);
      drain();
      write_reg(cta_pkg::CSR_FRAME_OFFSET, 8'd2);
      write_reg(cta_pkg::CSR_RETAIN_GAPS, 8'd1);
      send_text("xxQ-a", 1'b1);
      send_text("T", 1'b1);

      for (ph = 0; chars_sent < ItemTarget; ph++) begin
         drain();
         quiet = 1'b0;
         pick  = $urandom_range(99);
         if (ph == 1) begin
            off = 255;
         end else if (ph == 3) begin
            off = 0;
         end else if (pick < 30) begin
            off = 0;
         end else if (pick < 85) begin
            off = $urandom_range(1, 3);
         end else if (pick < 95) begin
            off = $urandom_range(4, 40);
         end else begin
            off = $urandom_range(0, 255);
         end
         write_reg(cta_pkg::CSR_FRAME_OFFSET, off[7:0]);
         write_reg(cta_pkg::CSR_RETAIN_GAPS, (ph == 3) ? 8'd1 : 8'($urandom_range(1)));
         phases_run++;
         nseq = (off > 40) ? $urandom_range(1, 2) : $urandom_range(4, 10);
         if (ph == 4) begin
            quiet = 1'b1;
            nseq  = 12;
         end
         if (ph == 2) begin
            holdoff_pending = 1'b1;
         end
         for (int s = 0; s < nseq && chars_sent < ItemTarget; s++) begin
            if (ph == 5 && s == nseq / 2) begin
               drain();
            end
            if (ph == 1 && s == 0) begin
               len = off + $urandom_range(3, 20);
            end else if ($urandom_range(99) < 20) begin
               len = $urandom_range(1, off + 3);
            end else begin
               len = off + $urandom_range(1, 30);
            end
            noisy = ($urandom_range(99) < 30);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(3))
                  0: ch = cta_pkg::CHAR_T;
                  1: ch = cta_pkg::CHAR_C;
                  2: ch = cta_pkg::CHAR_A;
                  default: ch = cta_pkg::CHAR_G;
               endcase
               if ($urandom_range(1)) begin
                  ch = ch + cta_pkg::CASE_SHIFT;
               end
               pick = $urandom_range(99);
               if (noisy && pick < 12) begin
                  ch = cta_pkg::CHAR_GAP;
               end else if (noisy && pick < 25) begin
                  ch = 8'($urandom);
               end
               send_char(ch, i == len - 1);
            end
         end
      end
      quiet = 1'b0;

      drain();
      repeat (TailCycles) @(posedge clock);
      $display("covered %0d characters over %0d register settings: %0d results, %0d residues,",
               tracker.chars_seen, phases_run + 2, tracker.residues_seen, tracker.codons_seen);
      $display("%0d sequence ends, frame offsets up to 255, gaps kept and dropped, long hold-off",
               tracker.end_marks);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("codon_to_amino_acid_translator regression: pass");
      end else begin
         $display("codon_to_amino_acid_translator regression: fail");
      end
      $finish;
   end

endmodule
